// ===== rtl/core/twcq_pkg.sv =====
// ----------------------------------------------------------------------------
// twcq_pkg
// Types and constants shared by the two-class weighted queue core.
// ----------------------------------------------------------------------------
package twcq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 128;
  localparam int unsigned TAG_W            = 32;
  localparam int unsigned AGE_W            = 8;
  localparam int unsigned APB_DATA_W       = 32;
  localparam int unsigned APB_ADDR_W       = 2;
  localparam logic [AGE_W-1:0] PRIO_AGE_RST = 8'd60;

  typedef logic [TAG_W-1:0] tag_t;
  typedef logic [AGE_W-1:0] age_t;

  // register byte addresses
  typedef enum logic [APB_ADDR_W-1:0] {
    REG_PRIO_AGE = 2'd0
  } reg_addr_e;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ENQUEUED = 2'd0,
    ST_FULL     = 2'd1,
    ST_DEQUEUED = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_READ = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    tag_t tag;
    age_t age;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic accept;   // take the input item this cycle
    logic capture;  // load the dequeued entry into the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy; // output register holds an item that is not taken this cycle
  } dp_stat_t;

endpackage

// ===== rtl/core/twcq_if.sv =====
// ----------------------------------------------------------------------------
// twcq_if
// Valid/ready channels for commands into and results out of the queue core.
// ----------------------------------------------------------------------------
interface twcq_in_if;
  logic            valid;
  logic            ready;
  logic            cmd;
  twcq_pkg::tag_t  tag;
  twcq_pkg::age_t  age;

  modport source (output valid, cmd, tag, age, input ready);
  modport sink   (input valid, cmd, tag, age, output ready);
endinterface

interface twcq_out_if;
  logic              valid;
  logic              ready;
  twcq_pkg::status_e status;
  twcq_pkg::tag_t    out_tag;
  twcq_pkg::age_t    out_age;
  logic              high_class;

  modport source (output valid, status, out_tag, out_age, high_class, input ready);
  modport sink   (input valid, status, out_tag, out_age, high_class, output ready);
endinterface

// ===== rtl/core/twcq_ctrl.sv =====
// ----------------------------------------------------------------------------
// twcq_ctrl
// Command sequencer: accepts one item at a time and waits out the memory
// read of a dequeue.
// ----------------------------------------------------------------------------
module twcq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  output logic                in_ready_o,
  input  twcq_pkg::dp_stat_t  stat_i,
  output twcq_pkg::ctrl_cmd_t cmd_o
);
  import twcq_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.accept   = 1'b0;
    cmd_o.capture  = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        // take an item only when the output slot frees up by this edge
        in_ready_o   = !stat_i.out_busy;
        cmd_o.accept = in_valid_i && !stat_i.out_busy;
        if (cmd_o.accept && (cmd_e'(in_cmd_i) == CMD_DEQ)) begin
          state_d = CTRL_READ;
        end
      end
      CTRL_READ: begin
        cmd_o.capture = 1'b1;
        state_d       = CTRL_IDLE;
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/twcq_dp.sv =====
// ----------------------------------------------------------------------------
// twcq_dp
// Datapath: two FIFO memories with head/count pointers, turn counter,
// priority threshold register and the output register.
// ----------------------------------------------------------------------------
module twcq_dp #(
  parameter int unsigned QueueDepth = twcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [twcq_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [twcq_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [twcq_pkg::APB_DATA_W-1:0]      prdata,
  // input payload
  input  logic                                 in_cmd_i,
  input  twcq_pkg::tag_t                       in_tag_i,
  input  twcq_pkg::age_t                       in_age_i,
  // output channel
  input  logic                                 out_ready_i,
  output logic                                 out_valid_o,
  output twcq_pkg::status_e                    out_status_o,
  output twcq_pkg::tag_t                       out_tag_o,
  output twcq_pkg::age_t                       out_age_o,
  output logic                                 out_high_o,
  // control
  input  twcq_pkg::ctrl_cmd_t                  cmd_i,
  output twcq_pkg::dp_stat_t                   stat_o
);
  import twcq_pkg::*;

  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] CntFull  = CW'(QueueDepth);
  localparam logic [AW:0]   DepthW   = (AW+1)'(QueueDepth);
  localparam logic [AW-1:0] HeadLast = AW'(QueueDepth - 1);

  entry_t hi_mem [QueueDepth];
  entry_t nm_mem [QueueDepth];
  entry_t hi_rd_q, nm_rd_q;

  logic [AW-1:0] hi_head_q, hi_head_d, nm_head_q, nm_head_d;
  logic [CW-1:0] hi_cnt_q, hi_cnt_d, nm_cnt_q, nm_cnt_d;
  logic [1:0]    turn_q, turn_d;
  age_t          prio_q;

  logic          src_hi_q, deq_ok_q;
  logic          out_valid_q;
  status_e       out_status_q;
  tag_t          out_tag_q;
  age_t          out_age_q;
  logic          out_high_q;

  logic          is_deq, enq_hi, hi_ne, nm_ne, hi_full, nm_full;
  logic          pick_hi, deq_ok, hi_wr, nm_wr;
  logic [AW:0]   hi_sum, nm_sum;
  logic [AW-1:0] hi_tail, nm_tail;
  entry_t        wr_entry;

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prio_q <= PRIO_AGE_RST;
    end else if (psel && penable && pwrite && (paddr == REG_PRIO_AGE)) begin
      prio_q <= pwdata[AGE_W-1:0];
    end
  end

  assign prdata = (paddr == REG_PRIO_AGE) ? APB_DATA_W'(prio_q) : '0;

  assign is_deq   = (cmd_e'(in_cmd_i) == CMD_DEQ);
  assign enq_hi   = (in_age_i >= prio_q);
  assign hi_ne    = (hi_cnt_q != '0);
  assign nm_ne    = (nm_cnt_q != '0);
  assign hi_full  = (hi_cnt_q == CntFull);
  assign nm_full  = (nm_cnt_q == CntFull);
  assign pick_hi  = ((turn_q == 2'd0) && hi_ne) || (!nm_ne && hi_ne);
  assign deq_ok   = hi_ne || nm_ne;
  assign wr_entry = '{tag: in_tag_i, age: in_age_i};

  // tail = head + count, wrapped once
  assign hi_sum  = {1'b0, hi_head_q} + (AW+1)'(hi_cnt_q);
  assign nm_sum  = {1'b0, nm_head_q} + (AW+1)'(nm_cnt_q);
  assign hi_tail = (hi_sum >= DepthW) ? AW'(hi_sum - DepthW) : hi_sum[AW-1:0];
  assign nm_tail = (nm_sum >= DepthW) ? AW'(nm_sum - DepthW) : nm_sum[AW-1:0];

  assign hi_wr = cmd_i.accept && !is_deq && enq_hi && !hi_full;
  assign nm_wr = cmd_i.accept && !is_deq && !enq_hi && !nm_full;

  always_ff @(posedge clk_i) begin
    if (hi_wr) begin
      hi_mem[hi_tail] <= wr_entry;
    end
    if (nm_wr) begin
      nm_mem[nm_tail] <= wr_entry;
    end
    if (cmd_i.accept && is_deq) begin
      hi_rd_q <= hi_mem[hi_head_q];
      nm_rd_q <= nm_mem[nm_head_q];
    end
  end

  always_comb begin
    hi_head_d = hi_head_q;
    nm_head_d = nm_head_q;
    hi_cnt_d  = hi_cnt_q;
    nm_cnt_d  = nm_cnt_q;
    turn_d    = turn_q;
    if (hi_wr) begin
      hi_cnt_d = hi_cnt_q + 1'b1;
    end
    if (nm_wr) begin
      nm_cnt_d = nm_cnt_q + 1'b1;
    end
    if (cmd_i.accept && is_deq && deq_ok) begin
      turn_d = turn_q + 2'd1;
      if (pick_hi) begin
        hi_head_d = (hi_head_q == HeadLast) ? '0 : hi_head_q + 1'b1;
        hi_cnt_d  = hi_cnt_q - 1'b1;
      end else begin
        nm_head_d = (nm_head_q == HeadLast) ? '0 : nm_head_q + 1'b1;
        nm_cnt_d  = nm_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_head_q <= '0;
      nm_head_q <= '0;
      hi_cnt_q  <= '0;
      nm_cnt_q  <= '0;
      turn_q    <= '0;
    end else begin
      hi_head_q <= hi_head_d;
      nm_head_q <= nm_head_d;
      hi_cnt_q  <= hi_cnt_d;
      nm_cnt_q  <= nm_cnt_d;
      turn_q    <= turn_d;
    end
  end

  // hold the dequeue decision until the read data arrives
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && is_deq) begin
      src_hi_q <= pick_hi;
      deq_ok_q <= deq_ok;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((cmd_i.accept && !is_deq) || cmd_i.capture) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && !is_deq) begin
      out_status_q <= ((enq_hi && hi_full) || (!enq_hi && nm_full)) ? ST_FULL : ST_ENQUEUED;
      out_tag_q    <= '0;
      out_age_q    <= '0;
      out_high_q   <= 1'b0;
    end else if (cmd_i.capture) begin
      if (deq_ok_q) begin
        out_status_q <= ST_DEQUEUED;
        out_tag_q    <= src_hi_q ? hi_rd_q.tag : nm_rd_q.tag;
        out_age_q    <= src_hi_q ? hi_rd_q.age : nm_rd_q.age;
        out_high_q   <= src_hi_q;
      end else begin
        out_status_q <= ST_EMPTY;
        out_tag_q    <= '0;
        out_age_q    <= '0;
        out_high_q   <= 1'b0;
      end
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_status_o    = out_status_q;
  assign out_tag_o       = out_tag_q;
  assign out_age_o       = out_age_q;
  assign out_high_o      = out_high_q;

endmodule

// ===== rtl/core/two_class_weighted_queue_core.sv =====
// ----------------------------------------------------------------------------
// two_class_weighted_queue_core
// Enqueue by age class into two FIFOs, dequeue by a 2-bit weighted turn.
// ----------------------------------------------------------------------------
// Results: an enqueue result is registered in the cycle after accept; a dequeue
//   result goes through the registered FIFO memory read, then the output reg.
// Throughput: one enqueue per cycle unless the output stalls; no new command is
//   taken during a dequeue's memory read wait; results are buffered in an output reg.
// Reset: asynchronous, active low; FIFOs empty, turn 0, threshold 60.
//   Memory contents are not cleared.
module two_class_weighted_queue_core #(
  parameter int unsigned QueueDepth = twcq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  twcq_in_if.sink                         cmd_i,
  twcq_out_if.source                      res_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twcq_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [twcq_pkg::APB_DATA_W-1:0] pwdata,
  output logic [twcq_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import twcq_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  assign pready = 1'b1;

  twcq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_cmd_i   (cmd_i.cmd),
    .in_ready_o (cmd_i.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  twcq_dp #(
    .QueueDepth (QueueDepth)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .in_cmd_i     (cmd_i.cmd),
    .in_tag_i     (cmd_i.tag),
    .in_age_i     (cmd_i.age),
    .out_ready_i  (res_o.ready),
    .out_valid_o  (res_o.valid),
    .out_status_o (res_o.status),
    .out_tag_o    (res_o.out_tag),
    .out_age_o    (res_o.out_age),
    .out_high_o   (res_o.high_class),
    .cmd_i        (ctrl_cmd),
    .stat_o       (dp_stat)
  );

endmodule

// ===== sim/two_class_weighted_queue_core_tb.sv =====
// ----------------------------------------------------------------------------
// two_class_weighted_queue_core_tb
// Self-checking bench for the two-class weighted queue core. Commands go in
// over the command channel with random gaps, and results are taken with random
// stalls. A behavioral model of both FIFOs, the turn counter and the age
// threshold predicts every result, which is then checked field by field.
// Directed tests cover the turn order, the threshold extremes and a full FIFO.
// Random phases follow, each with its own threshold and enqueue mix.
// ----------------------------------------------------------------------------
module two_class_weighted_queue_core_tb;
  import twcq_pkg::*;

  localparam int unsigned QDEPTH         = QUEUE_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned N_PHASES       = 8;
  localparam int unsigned PHASE_ITEMS    = 32;

  typedef struct {
    status_e status;
    tag_t    tag;
    age_t    age;
    logic    high_class;
  } outcome_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  twcq_in_if  cmd_if ();
  twcq_out_if res_if ();

  two_class_weighted_queue_core #(
    .QueueDepth(QDEPTH)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // model state
  entry_t   high_fifo[$];
  entry_t   normal_fifo[$];
  logic [1:0] turn;
  age_t     prio_age;
  outcome_t pending_results[$];

  int  err_count;
  int  sent_count;
  int  status_seen[4];
  int  high_seen;
  bit  send_idle;
  bit  recv_idle;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  task automatic report_error(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_error($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
  endtask

  // work out the result of one accepted command and advance the model
  function automatic void predict_command(cmd_e c, tag_t t, age_t a);
    outcome_t o;
    entry_t   e;
    bit       from_high;
    o.status     = ST_ENQUEUED;
    o.tag        = '0;
    o.age        = '0;
    o.high_class = 1'b0;
    e.tag        = t;
    e.age        = a;
    if (c == CMD_ENQ) begin
      if (a >= prio_age) begin
        if (high_fifo.size() < QDEPTH) high_fifo.push_back(e);
        else o.status = ST_FULL;
      end else begin
        if (normal_fifo.size() < QDEPTH) normal_fifo.push_back(e);
        else o.status = ST_FULL;
      end
    end else if (high_fifo.size() == 0 && normal_fifo.size() == 0) begin
      o.status = ST_EMPTY;
    end else begin
      // turn 0 prefers high; otherwise normal, falling back to high
      from_high = (turn == 2'd0 && high_fifo.size() != 0) || normal_fifo.size() == 0;
      if (from_high) e = high_fifo.pop_front();
      else e = normal_fifo.pop_front();
      o.status     = ST_DEQUEUED;
      o.tag        = e.tag;
      o.age        = e.age;
      o.high_class = from_high;
      turn         = turn + 2'd1;
    end
    pending_results.push_back(o);
  endfunction

  task automatic send_cmd(cmd_e c, tag_t t, age_t a);
    int gap;
    gap = send_idle ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid <= 1'b1;
    cmd_if.cmd   <= c;
    cmd_if.tag   <= t;
    cmd_if.age   <= a;
    do @(posedge clk_i); while (!cmd_if.ready);
    predict_command(c, t, a);
    sent_count++;
  endtask

  // drop valid and wait until every result is back and the core is quiet
  task automatic settle();
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(logic wr, reg_addr_e addr, logic [APB_DATA_W-1:0] wdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (wr) prio_age = wdata[AGE_W-1:0];
    else check_field("prio_age readback", prdata[AGE_W-1:0], prio_age);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_threshold(age_t v);
    apb_access(1'b1, REG_PRIO_AGE, {{(APB_DATA_W-AGE_W){1'b0}}, v});
    apb_access(1'b0, REG_PRIO_AGE, '0);
  endtask

  // mostly ages at and around the threshold, plus the extremes
  function automatic age_t pick_age();
    case ($urandom_range(0, 5))
      0: return 8'd0;
      1: return 8'd255;
      2: return prio_age;
      3: return prio_age - 8'd1;
      4: return prio_age + 8'd1;
      default: return age_t'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic test_basic_turns();
    send_cmd(CMD_DEQ, '0, '0);                  // both empty, turn holds
    send_cmd(CMD_ENQ, 32'h0000_0000, 8'd59);    // just below reset threshold
    send_cmd(CMD_ENQ, 32'hFFFF_FFFF, 8'd60);    // at threshold
    send_cmd(CMD_ENQ, 32'hA5A5_A5A5, 8'd0);
    send_cmd(CMD_ENQ, 32'h5A5A_5A5A, 8'd255);
    repeat (5) send_cmd(CMD_DEQ, 32'hFFFF_FFFF, 8'hFF);
    // turn 0 with the high FIFO empty serves normal
    send_cmd(CMD_ENQ, 32'h1234_5678, 8'd1);
    send_cmd(CMD_DEQ, '0, '0);
    settle();
  endtask

  task automatic test_threshold_extremes();
    set_threshold(8'd0);
    send_cmd(CMD_ENQ, 32'h0F0F_0F0F, 8'd0);
    settle();
    set_threshold(8'd255);
    send_cmd(CMD_ENQ, 32'hF0F0_F0F0, 8'd254);
    send_cmd(CMD_ENQ, 32'h8000_0001, 8'd255);
    settle();
  endtask

  task automatic test_high_full();
    set_threshold(8'd0);
    repeat (QDEPTH + 1) send_cmd(CMD_ENQ, tag_t'($urandom), age_t'($urandom_range(0, 255)));
    settle();
  endtask

  task automatic test_random_phases();
    int enq_pct;
    for (int p = 0; p < N_PHASES; p++) begin
      if (p == 0) set_threshold(8'd0);
      else if (p == 3) set_threshold(8'd255);
      else set_threshold(age_t'($urandom_range(0, 255)));
      enq_pct   = (p % 3 == 0) ? 80 : (p % 3 == 1) ? 50 : 25;
      send_idle = (p % 4 == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      recv_idle = (p % 4 == 2) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(1, 100) <= enq_pct)
          send_cmd(CMD_ENQ, tag_t'($urandom), pick_age());
        else
          send_cmd(CMD_DEQ, tag_t'($urandom), age_t'($urandom_range(0, 255)));
      end
      settle();
    end
  endtask

  // result side: random stalls, then check against the oldest prediction
  initial begin
    outcome_t want;
    int       stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = recv_idle ? $urandom_range(0, 8) : 0;
      repeat (stall) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
      end
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result, status %0d", res_if.status));
      end else begin
        want = pending_results.pop_front();
        check_field("status", res_if.status, want.status);
        check_field("out_tag", res_if.out_tag, want.tag);
        check_field("out_age", res_if.out_age, want.age);
        check_field("high_class", res_if.high_class, want.high_class);
        status_seen[want.status]++;
        if (want.high_class) high_seen++;
      end
    end
  end

  // end the run when nothing moves for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("timeout: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending_results.size());
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    err_count    = 0;
    sent_count   = 0;
    high_seen    = 0;
    status_seen  = '{default: 0};
    turn         = 2'd0;
    prio_age     = PRIO_AGE_RST;
    send_idle    = 1'b1;
    recv_idle    = 1'b1;
    rst_ni       = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    cmd_if.valid = 1'b0;
    cmd_if.cmd   = CMD_ENQ;
    cmd_if.tag   = '0;
    cmd_if.age   = '0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    apb_access(1'b0, REG_PRIO_AGE, '0);   // reset value of the threshold
    test_basic_turns();
    test_threshold_extremes();
    test_high_full();
    test_random_phases();

    settle();
    $display("%0d commands over %0d threshold phases, depth %0d per class", sent_count,
             N_PHASES, QDEPTH);
    $display("results: %0d enqueued, %0d rejected full, %0d dequeued (%0d high), %0d empty",
             status_seen[ST_ENQUEUED], status_seen[ST_FULL], status_seen[ST_DEQUEUED],
             high_seen, status_seen[ST_EMPTY]);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
